### src/svt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_pkg
// Shared types and constants of the sample voice trigger policy block.
// ----------------------------------------------------------------------------
package svt_pkg;

    // event function codes
    localparam logic [2:0] FUNC_TRIGGER   = 3'd0;
    localparam logic [2:0] FUNC_FUSE_STOP = 3'd1;
    localparam logic [2:0] FUNC_STOP_ALL  = 3'd2;
    localparam logic [2:0] FUNC_HUM       = 3'd3;
    localparam logic [2:0] FUNC_TICK      = 3'd4;

    // result command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_PITCH = 2'd2;

    // voice modes
    localparam logic [1:0] MODE_ONESHOT = 2'd0;
    localparam logic [1:0] MODE_HELD    = 2'd1;
    localparam logic [1:0] MODE_LATCHED = 2'd2;

    localparam logic [3:0]  IDLE_SAMPLE        = 4'd15;
    localparam logic [3:0]  HUM_SAMPLE         = 4'd14;
    localparam logic [2:0]  HUM_CHANNEL        = 3'd6;
    localparam logic [3:0]  TABLE_SIZE         = 4'd14;
    localparam logic [3:0]  CODE_LOW_NIBBLE    = 4'hF;
    localparam logic [3:0]  HOLD_TIMEOUT_RESET = 4'd6;
    // 49.0 in Q6.10
    localparam logic [15:0] PITCH_DIVIDEND     = 16'd50176;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] code;
        logic       hum_request;
        logic [7:0] hum_pitch_in;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  channel;
        logic [3:0]  sample;
        logic        looping;
        logic [15:0] pitch_ratio;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [3:0] sample;
        logic [2:0] voice;
        logic [1:0] mode;
    } trig_entry_t;

    typedef enum logic [2:0] {
        OP_TRIGGER,
        OP_FUSE,
        OP_STOP_ALL,
        OP_HUM,
        OP_TICK
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [3:0] sample;
        logic [2:0] voice;
        logic [1:0] mode;
        logic       hum_request;
        logic [7:0] hum_pitch;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_WALK,
        BK_FLUSH,
        BK_DIV,
        BK_PITCH
    } back_state_t;

    function automatic trig_entry_t trig_lookup(input logic [3:0] idx);
        trig_entry_t e;
        case (idx)
            4'd0:    e = '{sample: 4'd0,  voice: 3'd1, mode: MODE_ONESHOT};
            4'd1:    e = '{sample: 4'd1,  voice: 3'd0, mode: MODE_ONESHOT};
            4'd2:    e = '{sample: 4'd2,  voice: 3'd3, mode: MODE_ONESHOT};
            4'd3:    e = '{sample: 4'd3,  voice: 3'd0, mode: MODE_ONESHOT};
            4'd4:    e = '{sample: 4'd4,  voice: 3'd3, mode: MODE_ONESHOT};
            4'd5:    e = '{sample: 4'd5,  voice: 3'd2, mode: MODE_ONESHOT};
            4'd6:    e = '{sample: 4'd6,  voice: 3'd5, mode: MODE_ONESHOT};
            4'd7:    e = '{sample: 4'd7,  voice: 3'd4, mode: MODE_HELD};
            4'd8:    e = '{sample: 4'd8,  voice: 3'd0, mode: MODE_LATCHED};
            4'd9:    e = '{sample: 4'd9,  voice: 3'd3, mode: MODE_LATCHED};
            4'd10:   e = '{sample: 4'd10, voice: 3'd0, mode: MODE_ONESHOT};
            4'd11:   e = '{sample: 4'd11, voice: 3'd0, mode: MODE_HELD};
            4'd12:   e = '{sample: 4'd12, voice: 3'd3, mode: MODE_HELD};
            4'd13:   e = '{sample: 4'd13, voice: 3'd1, mode: MODE_ONESHOT};
            default: e = '{sample: IDLE_SAMPLE, voice: 3'd0, mode: MODE_ONESHOT};
        endcase
        return e;
    endfunction

endpackage

### src/svt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_front
// Accepts event words, drops invalid ones and turns the rest into queue ops.
// ----------------------------------------------------------------------------
module svt_front (
    input  logic             in_valid,
    output logic             in_stall,
    input  svt_pkg::in_word_t in_data,
    input  logic             q_full,
    output logic             push,
    output svt_pkg::op_t     push_op
);
    import svt_pkg::*;

    logic        accept;
    logic        code_ok;
    logic        func_ok;
    trig_entry_t entry;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign entry    = trig_lookup(in_data.code[7:4]);
    assign code_ok  = (in_data.code[7:4] < TABLE_SIZE) &&
                      (in_data.code[3:0] == CODE_LOW_NIBBLE);

    always_comb
    begin
        push_op.kind        = OP_TRIGGER;
        push_op.sample      = entry.sample;
        push_op.voice       = entry.voice;
        push_op.mode        = entry.mode;
        push_op.hum_request = in_data.hum_request;
        push_op.hum_pitch   = in_data.hum_pitch_in;
        func_ok             = 1'b1;
        case (in_data.func)
            FUNC_TRIGGER:
            begin
                push_op.kind = OP_TRIGGER;
                func_ok      = code_ok;
            end
            FUNC_FUSE_STOP: push_op.kind = OP_FUSE;
            FUNC_STOP_ALL:  push_op.kind = OP_STOP_ALL;
            FUNC_HUM:       push_op.kind = OP_HUM;
            FUNC_TICK:      push_op.kind = OP_TICK;
            default:        func_ok = 1'b0;
        endcase
    end

    // dropped words are still taken, they just never reach the queue
    assign push = accept && func_ok;

endmodule

### src/svt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_queue
// Short op queue between the front decoder and the back sequencer.
// ----------------------------------------------------------------------------
module svt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  svt_pkg::op_t        push_op,
    input  logic                pop,
    output svt_pkg::op_t        head,
    output svt_pkg::q_status_t  status
);
    import svt_pkg::*;

    op_t                slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = Q_CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = Q_CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### src/svt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_back
// Voice state, frame counter, hum state and the command sequencer with the
// output register and a serial pitch divider.
// ----------------------------------------------------------------------------
module svt_back #(
    parameter int VOICES = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [3:0]         hold_frames,
    input  svt_pkg::op_t       head,
    input  svt_pkg::q_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output svt_pkg::out_word_t out_data
);
    import svt_pkg::*;

    localparam int VIDX_W = $clog2(VOICES);
    localparam logic [VIDX_W-1:0] IDX_LAST = VIDX_W'(VOICES - 1);
    localparam logic [VIDX_W-1:0] IDX_FUSE_A = VIDX_W'(0);
    localparam logic [VIDX_W-1:0] IDX_FUSE_B = VIDX_W'(3);

    back_state_t       state_reg;
    back_state_t       state_next;
    op_t               op_reg;
    logic [VIDX_W-1:0] idx_reg;
    logic              pend_valid_reg;
    logic [VIDX_W-1:0] pend_ch_reg;
    logic [31:0]       frame_reg;
    logic              hum_active_reg;
    logic [7:0]        hum_pitch_reg;
    logic [8:0]        rem_reg;
    logic [15:0]       quo_reg;
    logic [3:0]        div_cnt_reg;
    logic              out_valid_reg;
    out_word_t         out_data_reg;
    logic [3:0]        voice_sample_reg [VOICES];
    logic [1:0]        voice_mode_reg   [VOICES];
    logic [31:0]       voice_trig_reg   [VOICES];

    logic              out_free;
    logic [VIDX_W-1:0] op_voice;
    logic [VIDX_W-1:0] rd_idx;
    logic [3:0]        rd_sample;
    logic [1:0]        rd_mode;
    logic [31:0]       rd_trig;
    logic [31:0]       age;
    logic              trig_refresh;
    logic              walk_hit;
    logic              walk_blocked;
    logic              walk_end;
    logic [8:0]        divisor;
    logic [9:0]        rem_shift;
    logic [9:0]        rem_diff;
    logic              div_ge;

    logic              emit;
    out_word_t         emit_word;
    logic              do_refresh;
    logic              do_trig_start;
    logic              do_tick_inc;
    logic              do_hum_on;
    logic              do_hum_off;
    logic              do_div_start;
    logic              do_walk_init;
    logic              do_walk_step;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign op_voice  = VIDX_W'(op_reg.voice);
    assign rd_idx    = (state_reg == BK_WALK) ? idx_reg : op_voice;
    assign rd_sample = voice_sample_reg[rd_idx];
    assign rd_mode   = voice_mode_reg[rd_idx];
    assign rd_trig   = voice_trig_reg[rd_idx];
    assign age       = frame_reg - rd_trig;

    assign trig_refresh = (op_reg.mode != MODE_ONESHOT) && (rd_sample == op_reg.sample);

    always_comb
    begin
        case (op_reg.kind)
            OP_FUSE:     walk_hit = (idx_reg == IDX_FUSE_A) || (idx_reg == IDX_FUSE_B);
            OP_STOP_ALL: walk_hit = 1'b1;
            OP_TICK:     walk_hit = (rd_sample != IDLE_SAMPLE) && (rd_mode == MODE_HELD) &&
                                    (age > 32'(hold_frames));
            default:     walk_hit = 1'b0;
        endcase
    end

    // a stop is held back one hit so the final one can carry the last flag
    assign walk_blocked = walk_hit && pend_valid_reg && !out_free;
    assign walk_end     = (idx_reg == IDX_LAST);

    // restoring divider, one quotient bit per cycle
    assign divisor   = {1'b0, hum_pitch_reg} + 9'd1;
    assign rem_shift = {rem_reg, quo_reg[15]};
    assign div_ge    = rem_shift >= {1'b0, divisor};
    assign rem_diff  = rem_shift - {1'b0, divisor};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                case (op_reg.kind)
                    OP_TRIGGER:
                    begin
                        if (trig_refresh || out_free)
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                    OP_FUSE, OP_STOP_ALL, OP_TICK: state_next = BK_WALK;
                    OP_HUM:
                    begin
                        if (!op_reg.hum_request)
                        begin
                            if (!hum_active_reg || out_free)
                            begin
                                state_next = BK_IDLE;
                            end
                        end
                        else if (!hum_active_reg)
                        begin
                            if (out_free)
                            begin
                                state_next = BK_DIV;
                            end
                        end
                        else if (op_reg.hum_pitch != hum_pitch_reg)
                        begin
                            state_next = BK_DIV;
                        end
                        else
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                    default: state_next = BK_IDLE;
                endcase
            end
            BK_WALK:
            begin
                if (!walk_blocked && walk_end)
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_DIV:
            begin
                if (div_cnt_reg == 4'd15)
                begin
                    state_next = BK_PITCH;
                end
            end
            BK_PITCH:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        emit          = 1'b0;
        emit_word     = '0;
        do_refresh    = 1'b0;
        do_trig_start = 1'b0;
        do_tick_inc   = 1'b0;
        do_hum_on     = 1'b0;
        do_hum_off    = 1'b0;
        do_div_start  = 1'b0;
        do_walk_init  = 1'b0;
        do_walk_step  = 1'b0;
        case (state_reg)
            BK_IDLE: pop = !q_status.empty;
            BK_EXEC:
            begin
                case (op_reg.kind)
                    OP_TRIGGER:
                    begin
                        if (trig_refresh)
                        begin
                            do_refresh = 1'b1;
                        end
                        else if (out_free)
                        begin
                            emit              = 1'b1;
                            emit_word.command = CMD_START;
                            emit_word.channel = op_reg.voice;
                            emit_word.sample  = op_reg.sample;
                            emit_word.looping = (op_reg.mode != MODE_ONESHOT);
                            emit_word.last    = 1'b1;
                            do_trig_start     = 1'b1;
                        end
                    end
                    OP_FUSE: do_walk_init = 1'b1;
                    OP_STOP_ALL:
                    begin
                        do_walk_init = 1'b1;
                        do_hum_off   = 1'b1;
                    end
                    OP_TICK:
                    begin
                        do_walk_init = 1'b1;
                        do_tick_inc  = 1'b1;
                    end
                    OP_HUM:
                    begin
                        if (!op_reg.hum_request)
                        begin
                            if (hum_active_reg && out_free)
                            begin
                                emit              = 1'b1;
                                emit_word.command = CMD_STOP;
                                emit_word.channel = HUM_CHANNEL;
                                emit_word.last    = 1'b1;
                                do_hum_off        = 1'b1;
                            end
                        end
                        else if (!hum_active_reg)
                        begin
                            if (out_free)
                            begin
                                emit              = 1'b1;
                                emit_word.command = CMD_START;
                                emit_word.channel = HUM_CHANNEL;
                                emit_word.sample  = HUM_SAMPLE;
                                emit_word.looping = 1'b1;
                                do_hum_on         = 1'b1;
                                do_div_start      = 1'b1;
                            end
                        end
                        else if (op_reg.hum_pitch != hum_pitch_reg)
                        begin
                            do_div_start = 1'b1;
                        end
                    end
                    default: pop = 1'b0;
                endcase
            end
            BK_WALK:
            begin
                if (!walk_blocked)
                begin
                    do_walk_step = 1'b1;
                    if (walk_hit && pend_valid_reg)
                    begin
                        emit              = 1'b1;
                        emit_word.command = CMD_STOP;
                        emit_word.channel = 3'(pend_ch_reg);
                    end
                end
            end
            BK_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    emit              = 1'b1;
                    emit_word.command = CMD_STOP;
                    emit_word.channel = 3'(pend_ch_reg);
                    emit_word.last    = 1'b1;
                end
            end
            BK_PITCH:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_word.command     = CMD_PITCH;
                    emit_word.channel     = HUM_CHANNEL;
                    emit_word.pitch_ratio = quo_reg;
                    emit_word.last        = 1'b1;
                end
            end
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            frame_reg      <= '0;
            hum_active_reg <= 1'b0;
            hum_pitch_reg  <= '0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                voice_sample_reg[i] <= IDLE_SAMPLE;
                voice_mode_reg[i]   <= MODE_ONESHOT;
                voice_trig_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= emit || (out_valid_reg && out_stall);
            if (do_refresh)
            begin
                voice_trig_reg[op_voice] <= frame_reg;
            end
            if (do_trig_start)
            begin
                voice_sample_reg[op_voice] <= op_reg.sample;
                voice_mode_reg[op_voice]   <= op_reg.mode;
                voice_trig_reg[op_voice]   <= frame_reg;
            end
            if (do_tick_inc)
            begin
                frame_reg <= frame_reg + 32'd1;
            end
            if (do_hum_on)
            begin
                hum_active_reg <= 1'b1;
            end
            if (do_hum_off)
            begin
                hum_active_reg <= 1'b0;
            end
            if (do_div_start)
            begin
                hum_pitch_reg <= op_reg.hum_pitch;
                div_cnt_reg   <= '0;
            end
            else if (state_reg == BK_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            if (do_walk_init)
            begin
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (do_walk_step)
            begin
                if (walk_hit)
                begin
                    voice_sample_reg[idx_reg] <= IDLE_SAMPLE;
                    pend_valid_reg            <= 1'b1;
                end
                if (!walk_end)
                begin
                    idx_reg <= VIDX_W'(idx_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= emit_word;
        end
        if (state_reg == BK_IDLE && !q_status.empty)
        begin
            op_reg <= head;
        end
        if (do_walk_step && walk_hit)
        begin
            pend_ch_reg <= idx_reg;
        end
        if (do_div_start)
        begin
            rem_reg <= '0;
            quo_reg <= PITCH_DIVIDEND;
        end
        else if (state_reg == BK_DIV)
        begin
            rem_reg <= div_ge ? rem_diff[8:0] : rem_shift[8:0];
            quo_reg <= {quo_reg[14:0], div_ge};
        end
    end

endmodule

### src/sample_voice_trigger_policy_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_trigger_policy_core
// Turns sound events into start, stop and pitch commands for the voices.
// ----------------------------------------------------------------------------
//  channel  | handshake          | word
//  ---------+--------------------+----------------------------------------
//  in       | in_valid/in_stall  | in_data: func, code, hum request, pitch
//  out      | out_valid/out_stall| out_data: command, channel, sample, ...
//  cfg      | cfg_valid/cfg_ready| cfg_data: hold timeout (4 bits)
//
// a trigger or hum stop is popped in the idle state and its word issued
// from the exec state; frame tick, stop all and fuse stop walk every voice;
// a hum start or pitch change runs the serial divider; a word waiting on
// out_stall holds the sequencer back
// a 4-word queue sits between decode and sequencer; in_stall is queue full
// rst_n clears all voices to idle, the frame counter and the hum state
// ----------------------------------------------------------------------------
module sample_voice_trigger_policy_core #(
    parameter int VOICES = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  svt_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output svt_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data
);
    import svt_pkg::*;

    logic       cfg_write;
    logic [3:0] hold_reg;
    logic       push;
    op_t        push_op;
    op_t        head;
    q_status_t  q_status;
    logic       pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= HOLD_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            hold_reg <= cfg_data;
        end
    end

    svt_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_status.full),
        .push     (push),
        .push_op  (push_op)
    );

    svt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .status  (q_status)
    );

    svt_back #(
        .VOICES (VOICES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .hold_frames  (hold_reg),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

`ifndef SYNTHESIS
    // pitch words only go to the hum voice and always close the event
    a_pitch_on_hum : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.command == CMD_PITCH |->
            out_data.channel == HUM_CHANNEL && out_data.last)
        else $error("pitch word not on hum voice or not last");

    // a hum start is never marked last, as its pitch word follows it
    a_hum_start_not_last : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.command == CMD_START && out_data.sample == HUM_SAMPLE |->
            !out_data.last)
        else $error("hum start marked last");

    a_ratio_only_on_pitch : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.command != CMD_PITCH |-> out_data.pitch_ratio == 16'd0)
        else $error("pitch ratio set on a non-pitch word");

    // an empty queue is never popped
    a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");
`endif

endmodule

### tb/sample_voice_trigger_policy_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_trigger_policy_core_test
// Sends sound events through the trigger policy block and checks every
// start, stop and pitch command against a voice-state model kept here,
// across several hold timeout settings, with random sender gaps and stalls.
// ----------------------------------------------------------------------------
module sample_voice_trigger_policy_core_test;
    import svt_pkg::*;

    localparam int VOICES         = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RANDOM_EVENTS  = 132;
    localparam int PHASES         = 4;
    localparam int MAX_SHOWN      = 10;
    localparam logic [2:0] FUNC_FIRST_UNUSED = FUNC_TICK + 3'd1;

    // fixed trigger map, indexed by the upper nibble of a valid code
    localparam trig_entry_t TRIGGER_LUT [14] = '{
        '{4'd0,  3'd1, MODE_ONESHOT}, '{4'd1,  3'd0, MODE_ONESHOT},
        '{4'd2,  3'd3, MODE_ONESHOT}, '{4'd3,  3'd0, MODE_ONESHOT},
        '{4'd4,  3'd3, MODE_ONESHOT}, '{4'd5,  3'd2, MODE_ONESHOT},
        '{4'd6,  3'd5, MODE_ONESHOT}, '{4'd7,  3'd4, MODE_HELD},
        '{4'd8,  3'd0, MODE_LATCHED}, '{4'd9,  3'd3, MODE_LATCHED},
        '{4'd10, 3'd0, MODE_ONESHOT}, '{4'd11, 3'd0, MODE_HELD},
        '{4'd12, 3'd3, MODE_HELD},    '{4'd13, 3'd1, MODE_ONESHOT}
    };

    class voice_cmd_scoreboard;
        out_word_t   pending_cmds[$];
        logic [3:0]  hold_frames;
        logic [3:0]  voice_sample [VOICES];
        logic [1:0]  voice_mode [VOICES];
        logic [31:0] voice_stamp [VOICES];
        logic [31:0] frame_count;
        bit          hum_on;
        logic [7:0]  hum_pitch;
        int          failures;

        function new();
            hold_frames = HOLD_TIMEOUT_RESET;
            for (int v = 0; v < VOICES; v++)
            begin
                voice_sample[v] = IDLE_SAMPLE;
                voice_mode[v]   = MODE_ONESHOT;
                voice_stamp[v]  = '0;
            end
            frame_count = '0;
            hum_on      = 1'b0;
            hum_pitch   = '0;
            failures    = 0;
        endfunction

        function void set_timeout(logic [3:0] value);
            hold_frames = value;
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction

        function out_word_t make_cmd(logic [1:0] cmd, int ch, logic [3:0] smp,
                                     logic loop, logic [15:0] ratio);
            out_word_t w;
            w.command     = cmd;
            w.channel     = 3'(ch);
            w.sample      = smp;
            w.looping     = loop;
            w.pitch_ratio = ratio;
            w.last        = 1'b0;
            return w;
        endfunction

        function string cmd_text(out_word_t w);
            return $sformatf("cmd=%0d ch=%0d smp=%0d loop=%0d ratio=%0d last=%0d",
                             w.command, w.channel, w.sample, w.looping,
                             w.pitch_ratio, w.last);
        endfunction

        // updates the voice state for one accepted word and queues its commands
        function void note_event(in_word_t w);
            out_word_t   batch[$];
            out_word_t   tail;
            trig_entry_t e;
            logic [31:0] ratio;
            bit          pitch_due;
            case (w.func)
                FUNC_TRIGGER:
                begin
                    if (w.code[7:4] < TABLE_SIZE && w.code[3:0] == CODE_LOW_NIBBLE)
                    begin
                        e = TRIGGER_LUT[w.code[7:4]];
                        if (e.mode != MODE_ONESHOT && voice_sample[e.voice] == e.sample)
                        begin
                            // loop already playing: only the hold is refreshed
                            voice_stamp[e.voice] = frame_count;
                        end
                        else
                        begin
                            batch.push_back(make_cmd(CMD_START, e.voice, e.sample,
                                                     e.mode != MODE_ONESHOT, '0));
                            voice_sample[e.voice] = e.sample;
                            voice_mode[e.voice]   = e.mode;
                            voice_stamp[e.voice]  = frame_count;
                        end
                    end
                end
                FUNC_FUSE_STOP:
                begin
                    batch.push_back(make_cmd(CMD_STOP, 0, '0, 1'b0, '0));
                    batch.push_back(make_cmd(CMD_STOP, 3, '0, 1'b0, '0));
                    voice_sample[0] = IDLE_SAMPLE;
                    voice_sample[3] = IDLE_SAMPLE;
                end
                FUNC_STOP_ALL:
                begin
                    for (int v = 0; v < VOICES; v++)
                    begin
                        batch.push_back(make_cmd(CMD_STOP, v, '0, 1'b0, '0));
                        voice_sample[v] = IDLE_SAMPLE;
                    end
                    hum_on = 1'b0;
                end
                FUNC_HUM:
                begin
                    if (!w.hum_request)
                    begin
                        if (hum_on)
                            batch.push_back(make_cmd(CMD_STOP, HUM_CHANNEL, '0, 1'b0, '0));
                        hum_on = 1'b0;
                    end
                    else
                    begin
                        pitch_due = !hum_on || (w.hum_pitch_in != hum_pitch);
                        if (!hum_on)
                            batch.push_back(make_cmd(CMD_START, HUM_CHANNEL, HUM_SAMPLE,
                                                     1'b1, '0));
                        hum_on = 1'b1;
                        if (pitch_due)
                        begin
                            hum_pitch = w.hum_pitch_in;
                            ratio = 32'(PITCH_DIVIDEND) / (32'(w.hum_pitch_in) + 32'd1);
                            batch.push_back(make_cmd(CMD_PITCH, HUM_CHANNEL, '0, 1'b0,
                                                     ratio[15:0]));
                        end
                    end
                end
                FUNC_TICK:
                begin
                    frame_count = frame_count + 32'd1;
                    for (int v = 0; v < VOICES; v++)
                    begin
                        if (voice_sample[v] != IDLE_SAMPLE && voice_mode[v] == MODE_HELD &&
                            (frame_count - voice_stamp[v]) > {28'd0, hold_frames})
                        begin
                            batch.push_back(make_cmd(CMD_STOP, v, '0, 1'b0, '0));
                            voice_sample[v] = IDLE_SAMPLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (batch.size() > 0)
            begin
                tail      = batch.pop_back();
                tail.last = 1'b1;
                batch.push_back(tail);
            end
            foreach (batch[i])
                pending_cmds.push_back(batch[i]);
        endfunction

        function void check_command(out_word_t got);
            out_word_t want;
            if (pending_cmds.size() == 0)
            begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display("unexpected command: %s", cmd_text(got));
                return;
            end
            want = pending_cmds.pop_front();
            if (got.command !== want.command || got.channel !== want.channel ||
                got.sample !== want.sample || got.looping !== want.looping ||
                got.pitch_ratio !== want.pitch_ratio || got.last !== want.last)
            begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display("mismatch: expected %s, got %s",
                             cmd_text(want), cmd_text(got));
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_word_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_word_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_data = '0;

    voice_cmd_scoreboard cmd_board = new();

    int         burst_left = 0;
    int         idle_cycles = 0;
    int         stall_tick = 0;
    int         stall_mode = 0;
    logic [7:0] last_hum_pitch = '0;

    sample_voice_trigger_policy_core #(
        .VOICES(VOICES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output checking, receiver stall pattern and watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            cmd_board.check_command(out_data);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        // stall mode is redrawn at regular intervals: none, random, or a repeating pattern
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= (stall_tick % 5) < 3;
        endcase
    end

    function automatic in_word_t make_event(logic [2:0] func, logic [7:0] code,
                                            logic req, logic [7:0] pitch);
        in_word_t w;
        w.func         = func;
        w.code         = code;
        w.hum_request  = req;
        w.hum_pitch_in = pitch;
        return w;
    endfunction

    task automatic send_event(in_word_t w);
        in_data  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cmd_board.note_event(w);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic drain_commands(int settle);
        in_valid <= 1'b0;
        while (cmd_board.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_timeout(logic [3:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cmd_board.set_timeout(value);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_word_t random_event();
        in_word_t    w;
        int unsigned pick;
        int unsigned held_idx [5] = '{7, 8, 9, 11, 12};
        w    = in_word_t'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            w.func = FUNC_TRIGGER;
            // lean on the looping entries so retrigger and timeout get exercised
            if ($urandom_range(0, 9) < 4)
                w.code = {4'(held_idx[$urandom_range(0, 4)]), CODE_LOW_NIBBLE};
            else
                w.code = {4'($urandom_range(0, TABLE_SIZE - 1)), CODE_LOW_NIBBLE};
        end
        else if (pick < 45)
        begin
            w.func = FUNC_TRIGGER;
            if (w.code[7:4] < TABLE_SIZE && w.code[3:0] == CODE_LOW_NIBBLE)
                w.code[0] = 1'b0;
        end
        else if (pick < 75)
            w.func = FUNC_TICK;
        else if (pick < 88)
        begin
            w.func        = FUNC_HUM;
            w.hum_request = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 2) == 0)
                w.hum_pitch_in = last_hum_pitch;
        end
        else if (pick < 92)
            w.func = FUNC_FUSE_STOP;
        else if (pick < 95)
            w.func = FUNC_STOP_ALL;
        else
            w.func = 3'(FUNC_FIRST_UNUSED + $urandom_range(0, 2));
        return w;
    endfunction

    initial
    begin
        in_word_t   directed[$];
        in_word_t   w;
        logic [3:0] phase_timeout [PHASES];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every table entry, loop retriggers, bad codes, hum corners, stops
        for (int i = 0; i < TABLE_SIZE; i++)
            directed.push_back(make_event(FUNC_TRIGGER, {4'(i), CODE_LOW_NIBBLE}, 1'b0, '0));
        directed.push_back(make_event(FUNC_TRIGGER, 8'h7F, 1'b1, 8'hFF));
        directed.push_back(make_event(FUNC_TRIGGER, 8'h8F, 1'b0, 8'h00));
        directed.push_back(make_event(FUNC_TRIGGER, 8'hEF, 1'b1, 8'h55));
        directed.push_back(make_event(FUNC_TRIGGER, 8'hFF, 1'b0, 8'hAA));
        directed.push_back(make_event(FUNC_TRIGGER, 8'h3E, 1'b0, 8'h00));
        directed.push_back(make_event(3'h7, 8'hFF, 1'b1, 8'hFF));
        directed.push_back(make_event(FUNC_HUM, 8'h00, 1'b1, 8'h00));
        directed.push_back(make_event(FUNC_HUM, 8'h00, 1'b1, 8'h00));
        directed.push_back(make_event(FUNC_HUM, 8'h00, 1'b1, 8'hFF));
        directed.push_back(make_event(FUNC_HUM, 8'h00, 1'b0, 8'hFF));
        directed.push_back(make_event(FUNC_HUM, 8'h00, 1'b0, 8'h00));
        directed.push_back(make_event(FUNC_FUSE_STOP, 8'h00, 1'b0, 8'h00));
        directed.push_back(make_event(FUNC_STOP_ALL, 8'h00, 1'b0, 8'h00));
        foreach (directed[i])
            send_event(directed[i]);
        last_hum_pitch = 8'hFF;

        phase_timeout[0] = 4'd15;
        phase_timeout[1] = 4'd1;
        phase_timeout[2] = 4'd0;
        phase_timeout[3] = 4'($urandom_range(2, 14));
        for (int p = 0; p < PHASES; p++)
        begin
            drain_commands(SETTLE_CYCLES);
            write_timeout(phase_timeout[p]);
            for (int i = 0; i < RANDOM_EVENTS / PHASES; i++)
            begin
                w = random_event();
                if (w.func == FUNC_HUM && w.hum_request)
                    last_hum_pitch = w.hum_pitch_in;
                send_event(w);
                if ($urandom_range(0, 29) == 0)
                    drain_commands(0);
            end
        end

        drain_commands(SETTLE_CYCLES);
        if (cmd_board.pending() != 0)
            $display("commands never issued: %0d", cmd_board.pending());
        if (cmd_board.failures == 0 && cmd_board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sample_voice_trigger_policy_core.f
src/svt_pkg.sv
src/svt_front.sv
src/svt_queue.sv
src/svt_back.sv
src/sample_voice_trigger_policy_core.sv
tb/sample_voice_trigger_policy_core_test.sv
